// File: rtl/planar_pixel_line_draw_core_macros.svh
// assertion macros for the planar pixel line draw core checker
// no dependencies
`ifndef PLANAR_PIXEL_LINE_DRAW_CORE_MACROS_SVH
`define PLANAR_PIXEL_LINE_DRAW_CORE_MACROS_SVH

// concurrent property checked on every clock
`define PPLD_ASSERT(lbl, ck, rn, prop) \
  lbl: assert property (@(posedge ck) disable iff (!(rn)) prop) \
    else $error("ppld assertion failed");

// antecedent now, consequent on the next clock
`define PPLD_ASSERT_NEXT(lbl, ck, rn, ante, cons) \
  `PPLD_ASSERT(lbl, ck, rn, (ante) |=> (cons))

`endif

// File: rtl/ppld_pkg.sv
// shared constants, codes and types for the planar pixel line draw core
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
package ppld_pkg;

  localparam int BYTES_PER_LINE = 80;
  localparam int LINES          = 512;
  localparam int PLANES         = 4;

  localparam int ROW_PIXELS = 8 * BYTES_PER_LINE;
  localparam int MEM_DEPTH  = BYTES_PER_LINE * LINES;
  localparam int ADDR_W     = $clog2(MEM_DEPTH);
  localparam int WORD_W     = 8 * PLANES;

  localparam int REQ_W   = 2;
  localparam int X_W     = 10;
  localparam int Y_W     = 9;
  localparam int E_W     = 10;
  localparam int COLOR_W = 4;
  localparam int PIX_W   = 4;
  localparam int MODE_W  = 2;

  // coordinate compare width, covers the largest row width and line count
  localparam int CW     = 12;
  localparam int BYTE_W = X_W - 3;
  localparam int ROW_W  = E_W;

  typedef enum logic [REQ_W-1:0] {
    REQ_PIXEL = 2'd0,
    REQ_READ  = 2'd1,
    REQ_HLINE = 2'd2,
    REQ_VLINE = 2'd3
  } req_t;

  typedef enum logic [MODE_W-1:0] {
    DM_SET = 2'd0,
    DM_XOR = 2'd1,
    DM_OR  = 2'd2,
    DM_AND = 2'd3
  } mode_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SETUP,
    ST_READ,
    ST_WRITE,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [WORD_W-1:0] wdata;
    logic              re;
    logic [ADDR_W-1:0] raddr;
  } mem_req_t;

  typedef struct packed {
    logic [2:0]         lo;
    logic [2:0]         hi;
    logic [COLOR_W-1:0] color;
    logic               xor_mode;
  } rmw_ctl_t;

endpackage
`default_nettype wire

// File: rtl/ppld_if.sv
// request and result channel interfaces of the planar pixel line draw core
// depends on ppld_pkg
`timescale 1ns / 1ps
`default_nettype none
interface ppld_req_if;
  import ppld_pkg::*;

  logic               valid;
  logic               ready;
  logic [REQ_W-1:0]   req_type;
  logic [X_W-1:0]     x_pos;
  logic [Y_W-1:0]     y_pos;
  logic [E_W-1:0]     end_coord;
  logic [COLOR_W-1:0] color;

  modport source (output valid, output req_type, output x_pos, output y_pos,
                  output end_coord, output color, input ready);
  modport sink   (input valid, input req_type, input x_pos, input y_pos,
                  input end_coord, input color, output ready);
endinterface

interface ppld_res_if;
  import ppld_pkg::*;

  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] pixel_value;
  logic             done_res;

  modport source (output valid, output pixel_value, output done_res, input ready);
  modport sink   (input valid, input pixel_value, input done_res, output ready);
endinterface
`default_nettype wire

// File: rtl/ppld_mem.sv
// plane store: one word per byte address, one byte lane per plane
// depends on ppld_pkg
`timescale 1ns / 1ps
`default_nettype none
module ppld_mem (
  input  logic                        clk,
  input  ppld_pkg::mem_req_t          mem_req,
  output logic [ppld_pkg::WORD_W-1:0] rd_data_r
);
  import ppld_pkg::*;

  logic [WORD_W-1:0] store [MEM_DEPTH];

  always_ff @(posedge clk) begin
    if (mem_req.we) begin
      store[mem_req.waddr] <= mem_req.wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_req.re) begin
      rd_data_r <= store[mem_req.raddr];
    end
  end

endmodule
`default_nettype wire

// File: rtl/ppld_rmw.sv
// shared byte-mask unit: builds the span mask and merges it into the planes by colour bit and mode
// depends on ppld_pkg
`timescale 1ns / 1ps
`default_nettype none
module ppld_rmw (
  input  ppld_pkg::rmw_ctl_t          rmw_ctl,
  input  logic [ppld_pkg::WORD_W-1:0] rd_word,
  output logic [ppld_pkg::WORD_W-1:0] new_word,
  output logic [ppld_pkg::PIX_W-1:0]  pix
);
  import ppld_pkg::*;

  logic [7:0]        mask;
  logic [PLANES-1:0] color_ext;
  logic [PLANES-1:0] plane_hit;

  assign mask      = (8'hFF >> rmw_ctl.lo) & (8'hFF << (3'd7 - rmw_ctl.hi));
  assign color_ext = PLANES'(rmw_ctl.color);

  always_comb begin
    for (int p = 0; p < PLANES; p++) begin
      plane_hit[p] = |(rd_word[8*p +: 8] & mask);
      if (rmw_ctl.xor_mode) begin
        new_word[8*p +: 8] = color_ext[p] ? (rd_word[8*p +: 8] ^ mask)
                                          : rd_word[8*p +: 8];
      end else begin
        new_word[8*p +: 8] = color_ext[p] ? (rd_word[8*p +: 8] | mask)
                                          : (rd_word[8*p +: 8] & ~mask);
      end
    end
  end

  assign pix = PIX_W'(plane_hit);

endmodule
`default_nettype wire

// File: rtl/ppld_ctrl.sv
// sequencer: store clear, request setup, byte and row walk, result register
// depends on ppld_pkg, ppld_if
`timescale 1ns / 1ps
`default_nettype none
module ppld_ctrl (
  input  logic                        clk,
  input  logic                        rst_n,
  ppld_req_if.sink                    in_chan,
  ppld_res_if.source                  out_chan,
  input  logic                        cfg_wr_en,
  input  logic [ppld_pkg::MODE_W-1:0] cfg_draw_mode,
  output ppld_pkg::mem_req_t          mem_req,
  output ppld_pkg::rmw_ctl_t          rmw_ctl,
  input  logic [ppld_pkg::WORD_W-1:0] rmw_word,
  input  logic [ppld_pkg::PIX_W-1:0]  rmw_pix
);
  import ppld_pkg::*;

  state_t             state_r, state_nxt;
  logic [MODE_W-1:0]  mode_r, mode_nxt;
  logic [ADDR_W-1:0]  clr_addr_r, clr_addr_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [PIX_W-1:0]   out_pix_r, out_pix_nxt;

  req_t               req_r, req_nxt;
  logic [X_W-1:0]     x_r, x_nxt;
  logic [Y_W-1:0]     y_r, y_nxt;
  logic [E_W-1:0]     e_r, e_nxt;
  logic [COLOR_W-1:0] color_r, color_nxt;
  logic               xor_r, xor_nxt;
  logic [ADDR_W-1:0]  addr_r, addr_nxt;
  logic [BYTE_W-1:0]  byte_r, byte_nxt;
  logic [BYTE_W-1:0]  first_r, first_nxt;
  logic [BYTE_W-1:0]  last_r, last_nxt;
  logic [2:0]         lo_r, lo_nxt;
  logic [2:0]         hi_r, hi_nxt;
  logic [ROW_W-1:0]   row_r, row_nxt;
  logic [ROW_W-1:0]   row_last_r, row_last_nxt;
  logic [PIX_W-1:0]   pix_r, pix_nxt;

  logic [CW-1:0]      xe, ye, ee, x2c, y2c, x2m1, y2m1;
  logic               su_empty;
  logic [BYTE_W-1:0]  su_last;
  logic [2:0]         su_hi;
  logic [ROW_W-1:0]   su_row_last;
  logic [ADDR_W-1:0]  row_base;
  logic               step_last;
  logic               out_free;

  // request setup: clipping and span bounds
  assign xe   = CW'(x_r);
  assign ye   = CW'(y_r);
  assign ee   = CW'(e_r);
  assign x2c  = (ee > CW'(ROW_PIXELS)) ? CW'(ROW_PIXELS) : ee;
  assign y2c  = (ee > CW'(LINES)) ? CW'(LINES) : ee;
  assign x2m1 = x2c - CW'(1);
  assign y2m1 = y2c - CW'(1);
  assign row_base = ADDR_W'(y_r) * ADDR_W'(BYTES_PER_LINE);

  always_comb begin
    su_empty    = (xe >= CW'(ROW_PIXELS)) || (ye >= CW'(LINES));
    su_last     = x_r[X_W-1:3];
    su_hi       = x_r[2:0];
    su_row_last = ROW_W'(y_r);
    case (req_r)
      REQ_HLINE: begin
        su_empty = (ye >= CW'(LINES)) || (xe >= x2c);
        su_last  = BYTE_W'(x2m1 >> 3);
        su_hi    = x2m1[2:0];
      end
      REQ_VLINE: begin
        su_empty    = (xe >= CW'(ROW_PIXELS)) || (ye >= y2c);
        su_row_last = ROW_W'(y2m1);
      end
      default: ;
    endcase
  end

  always_comb begin
    case (req_r)
      REQ_HLINE: step_last = (byte_r == last_r);
      REQ_VLINE: step_last = (row_r == row_last_r);
      default:   step_last = 1'b1;
    endcase
  end

  assign out_free = !out_valid_r || out_chan.ready;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_CLEAR: if (clr_addr_r == ADDR_W'(MEM_DEPTH - 1)) state_nxt = ST_IDLE;
      ST_IDLE:  if (in_chan.valid) state_nxt = ST_SETUP;
      ST_SETUP: state_nxt = su_empty ? ST_DONE : ST_READ;
      ST_READ:  state_nxt = ST_WRITE;
      ST_WRITE: state_nxt = step_last ? ST_DONE : ST_READ;
      ST_DONE:  if (out_free) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    mode_nxt      = mode_r;
    clr_addr_nxt  = clr_addr_r;
    out_valid_nxt = out_valid_r;
    out_pix_nxt   = out_pix_r;
    req_nxt       = req_r;
    x_nxt         = x_r;
    y_nxt         = y_r;
    e_nxt         = e_r;
    color_nxt     = color_r;
    xor_nxt       = xor_r;
    addr_nxt      = addr_r;
    byte_nxt      = byte_r;
    first_nxt     = first_r;
    last_nxt      = last_r;
    lo_nxt        = lo_r;
    hi_nxt        = hi_r;
    row_nxt       = row_r;
    row_last_nxt  = row_last_r;
    pix_nxt       = pix_r;
    mem_req       = '0;
    in_chan.ready = 1'b0;

    if (cfg_wr_en) begin
      mode_nxt = cfg_draw_mode;
    end
    if (out_chan.ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_CLEAR: begin
        mem_req.we    = 1'b1;
        mem_req.waddr = clr_addr_r;
        mem_req.wdata = '0;
        clr_addr_nxt  = clr_addr_r + ADDR_W'(1);
      end
      ST_IDLE: begin
        in_chan.ready = 1'b1;
        if (in_chan.valid) begin
          req_nxt   = req_t'(in_chan.req_type);
          x_nxt     = in_chan.x_pos;
          y_nxt     = in_chan.y_pos;
          e_nxt     = in_chan.end_coord;
          color_nxt = in_chan.color;
          xor_nxt   = (mode_t'(mode_r) == DM_XOR) &&
                      (req_t'(in_chan.req_type) != REQ_PIXEL);
        end
      end
      ST_SETUP: begin
        pix_nxt      = '0;
        first_nxt    = x_r[X_W-1:3];
        byte_nxt     = x_r[X_W-1:3];
        lo_nxt       = x_r[2:0];
        last_nxt     = su_last;
        hi_nxt       = su_hi;
        row_nxt      = ROW_W'(y_r);
        row_last_nxt = su_row_last;
        addr_nxt     = row_base + ADDR_W'(x_r[X_W-1:3]);
      end
      ST_READ: begin
        mem_req.re    = 1'b1;
        mem_req.raddr = addr_r;
      end
      ST_WRITE: begin
        if (req_r == REQ_READ) begin
          pix_nxt = rmw_pix;
        end else begin
          mem_req.we    = 1'b1;
          mem_req.waddr = addr_r;
          mem_req.wdata = rmw_word;
        end
        if (!step_last) begin
          row_nxt = row_r + ROW_W'(1);
          if (req_r == REQ_HLINE) begin
            byte_nxt = byte_r + BYTE_W'(1);
            addr_nxt = addr_r + ADDR_W'(1);
          end else begin
            addr_nxt = addr_r + ADDR_W'(BYTES_PER_LINE);
          end
        end
      end
      ST_DONE: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_pix_nxt   = pix_r;
        end
      end
      default: ;
    endcase
  end

  // span mask bounds for the current byte
  assign rmw_ctl.lo       = (byte_r == first_r) ? lo_r : 3'd0;
  assign rmw_ctl.hi       = (byte_r == last_r) ? hi_r : 3'd7;
  assign rmw_ctl.color    = color_r;
  assign rmw_ctl.xor_mode = xor_r;

  assign out_chan.valid       = out_valid_r;
  assign out_chan.pixel_value = out_pix_r;
  assign out_chan.done_res    = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      mode_r      <= DM_SET;
      clr_addr_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      mode_r      <= mode_nxt;
      clr_addr_r  <= clr_addr_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_pix_r  <= out_pix_nxt;
    req_r      <= req_nxt;
    x_r        <= x_nxt;
    y_r        <= y_nxt;
    e_r        <= e_nxt;
    color_r    <= color_nxt;
    xor_r      <= xor_nxt;
    addr_r     <= addr_nxt;
    byte_r     <= byte_nxt;
    first_r    <= first_nxt;
    last_r     <= last_nxt;
    lo_r       <= lo_nxt;
    hi_r       <= hi_nxt;
    row_r      <= row_nxt;
    row_last_r <= row_last_nxt;
    pix_r      <= pix_nxt;
  end

endmodule
`default_nettype wire

// File: rtl/planar_pixel_line_draw_core.sv
// from accept: setup, then a read and a write state per byte (horizontal line), row (vertical
// line) or single byte (pixel, read), then done; a clipped request goes from setup to done
// each touched byte is one read and (not for read requests) one write on the single port pair
// throughput: one request at a time, next request taken once the result is registered
// reset: synchronous active low, then a clearing pass that zeroes all 40960 store words,
// during which no request is taken; draw_mode resets to set
`timescale 1ns / 1ps
`default_nettype none
module planar_pixel_line_draw_core (
  input  logic                        clk,
  input  logic                        rst_n,
  ppld_req_if.sink                    in_chan,
  ppld_res_if.source                  out_chan,
  input  logic                        cfg_wr_en,
  input  logic [ppld_pkg::MODE_W-1:0] cfg_draw_mode
);
  import ppld_pkg::*;

  mem_req_t          mem_req;
  rmw_ctl_t          rmw_ctl;
  logic [WORD_W-1:0] rd_word;
  logic [WORD_W-1:0] new_word;
  logic [PIX_W-1:0]  pix;

  ppld_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_chan      (in_chan),
    .out_chan     (out_chan),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_draw_mode(cfg_draw_mode),
    .mem_req      (mem_req),
    .rmw_ctl      (rmw_ctl),
    .rmw_word     (new_word),
    .rmw_pix      (pix)
  );

  ppld_rmw u_rmw (
    .rmw_ctl (rmw_ctl),
    .rd_word (rd_word),
    .new_word(new_word),
    .pix     (pix)
  );

  ppld_mem u_mem (
    .clk      (clk),
    .mem_req  (mem_req),
    .rd_data_r(rd_word)
  );

endmodule
`default_nettype wire

// File: rtl/ppld_chk.sv
// port-level checker for the planar pixel line draw core, bound to the top level
// depends on ppld_pkg and planar_pixel_line_draw_core_macros.svh
`timescale 1ns / 1ps
`default_nettype none
`include "planar_pixel_line_draw_core_macros.svh"
module ppld_chk (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       in_valid,
  input logic                       in_ready,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic [ppld_pkg::PIX_W-1:0] out_pixel_value,
  input logic                       out_done_res
);

  `PPLD_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_pixel_value))
  `PPLD_ASSERT(a_done_set, clk, rst_n, out_valid |-> out_done_res)
  `PPLD_ASSERT_NEXT(a_busy_after_beat, clk, rst_n, in_valid && in_ready, !in_ready)
  `PPLD_ASSERT(a_result_while_busy, clk, rst_n, $rose(out_valid) |-> !$past(in_ready))

endmodule

bind planar_pixel_line_draw_core ppld_chk u_ppld_chk (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_chan.valid),
  .in_ready       (in_chan.ready),
  .out_valid      (out_chan.valid),
  .out_ready      (out_chan.ready),
  .out_pixel_value(out_chan.pixel_value),
  .out_done_res   (out_chan.done_res)
);
`default_nettype wire
